FILE: design/lfbp_pkg.sv
// Shared types, constants and frame decode functions for the LPC frame parser.
`timescale 1ns / 1ps

package lfbp_pkg;

  // Bit queue: oldest queued bit sits at the top (bit QUEUE_BITS-1).
  localparam int QUEUE_BITS  = 57;
  localparam int COUNT_BITS  = 6;
  localparam int BYTE_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int LEN_ENERGY   = 4;
  localparam int LEN_SILENT   = 4;
  localparam int LEN_REPEAT   = 11;
  localparam int LEN_UNVOICED = 29;
  localparam int LEN_VOICED   = 50;

  localparam logic [3:0] ENERGY_SILENT = 4'h0;
  localparam logic [3:0] ENERGY_STOP   = 4'hf;
  localparam logic [5:0] PITCH_NONE    = 6'd0;

  typedef enum logic [2:0] {
    KIND_SILENT   = 3'd0,
    KIND_REPEAT   = 3'd1,
    KIND_UNVOICED = 3'd2,
    KIND_VOICED   = 3'd3,
    KIND_STOP     = 3'd4
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    frame_kind_t frame_kind;
    logic [3:0]  energy_index;
    logic [5:0]  pitch_index;
    logic [4:0]  coef1_index;
    logic [4:0]  coef2_index;
    logic [3:0]  coef3_index;
    logic [3:0]  coef4_index;
    logic [3:0]  coef5_index;
    logic [3:0]  coef6_index;
    logic [3:0]  coef7_index;
    logic [8:0]  coefs8_to_10;
    logic        last_of_run;
  } out_word_t;

  // Result of looking at the frame at the head of the bit queue.
  typedef struct packed {
    logic                  done;
    logic                  stop;
    logic [COUNT_BITS-1:0] drop;
    out_word_t             rec;
  } frame_dec_t;

  // Records handed from the front end to the record queue in the same cycle.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

  // Byte bit 0 is the oldest, so it lands at the top.
  function automatic logic [BYTE_BITS-1:0] reverse_byte(input logic [BYTE_BITS-1:0] b);
    logic [BYTE_BITS-1:0] r;
    for (int i = 0; i < BYTE_BITS; i++) begin
      r[BYTE_BITS-1-i] = b[i];
    end
    return r;
  endfunction

  // Append a byte right behind the count queued bits.
  function automatic logic [QUEUE_BITS-1:0] append_byte(input logic [QUEUE_BITS-1:0] q,
                                                        input logic [COUNT_BITS-1:0] c,
                                                        input logic [BYTE_BITS-1:0] b);
    logic [QUEUE_BITS-1:0] ext;
    ext = {reverse_byte(b), {(QUEUE_BITS-BYTE_BITS){1'b0}}};
    return q | (ext >> c);
  endfunction

  // Classify the frame at the head of a top-aligned queue holding c bits.
  function automatic frame_dec_t decode_frame(input logic [QUEUE_BITS-1:0] q,
                                              input logic [COUNT_BITS-1:0] c);
    frame_dec_t d;
    logic [5:0] pitch;
    d = '0;
    pitch = q[QUEUE_BITS-6 -: 6];
    d.rec.energy_index = q[QUEUE_BITS-1 -: 4];
    if (c < COUNT_BITS'(LEN_ENERGY)) begin
      d.done = 1'b0;
    end else if (d.rec.energy_index == ENERGY_STOP) begin
      d.done = 1'b1;
      d.stop = 1'b1;
      d.rec.frame_kind = KIND_STOP;
    end else if (d.rec.energy_index == ENERGY_SILENT) begin
      d.done = 1'b1;
      d.drop = COUNT_BITS'(LEN_SILENT);
      d.rec.frame_kind = KIND_SILENT;
    end else if (c >= COUNT_BITS'(LEN_REPEAT)) begin
      if (q[QUEUE_BITS-5]) begin
        d.done = 1'b1;
        d.drop = COUNT_BITS'(LEN_REPEAT);
        d.rec.frame_kind = KIND_REPEAT;
        d.rec.pitch_index = pitch;
      end else if (pitch == PITCH_NONE) begin
        if (c >= COUNT_BITS'(LEN_UNVOICED)) begin
          d.done = 1'b1;
          d.drop = COUNT_BITS'(LEN_UNVOICED);
          d.rec.frame_kind = KIND_UNVOICED;
          d.rec.coef1_index = q[QUEUE_BITS-12 -: 5];
          d.rec.coef2_index = q[QUEUE_BITS-17 -: 5];
          d.rec.coef3_index = q[QUEUE_BITS-22 -: 4];
          d.rec.coef4_index = q[QUEUE_BITS-26 -: 4];
        end
      end else if (c >= COUNT_BITS'(LEN_VOICED)) begin
        d.done = 1'b1;
        d.drop = COUNT_BITS'(LEN_VOICED);
        d.rec.frame_kind = KIND_VOICED;
        d.rec.pitch_index = pitch;
        d.rec.coef1_index = q[QUEUE_BITS-12 -: 5];
        d.rec.coef2_index = q[QUEUE_BITS-17 -: 5];
        d.rec.coef3_index = q[QUEUE_BITS-22 -: 4];
        d.rec.coef4_index = q[QUEUE_BITS-26 -: 4];
        d.rec.coef5_index = q[QUEUE_BITS-30 -: 4];
        d.rec.coef6_index = q[QUEUE_BITS-34 -: 4];
        d.rec.coef7_index = q[QUEUE_BITS-38 -: 4];
        d.rec.coefs8_to_10 = q[QUEUE_BITS-42 -: 9];
      end
    end
    return d;
  endfunction

  // Remove a finished frame from the head; zeros fill in from the bottom.
  function automatic logic [QUEUE_BITS-1:0] drop_frame(input logic [QUEUE_BITS-1:0] q,
                                                       input frame_kind_t kind);
    logic [QUEUE_BITS-1:0] r;
    case (kind)
      KIND_SILENT:   r = q << LEN_SILENT;
      KIND_REPEAT:   r = q << LEN_REPEAT;
      KIND_UNVOICED: r = q << LEN_UNVOICED;
      KIND_VOICED:   r = q << LEN_VOICED;
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/lfbp_front.sv
// Front end: takes stream bytes, keeps the bit queue and parses up to two frames per byte.
`timescale 1ns / 1ps

module lfbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  lfbp_pkg::in_word_t byte_word,
  input  logic              room,
  output lfbp_pkg::push_t   push
);

  logic [lfbp_pkg::QUEUE_BITS-1:0] bits;
  logic [lfbp_pkg::QUEUE_BITS-1:0] bits_next;
  logic [lfbp_pkg::COUNT_BITS-1:0] count;
  logic [lfbp_pkg::COUNT_BITS-1:0] count_next;
  logic                            stopped;
  logic                            stopped_next;

  logic                            accept;
  logic [lfbp_pkg::QUEUE_BITS-1:0] q0, qa, qb;
  logic [lfbp_pkg::COUNT_BITS-1:0] c0, ca, cb;
  logic                            s0;
  lfbp_pkg::frame_dec_t            d1, d2;

  assign byte_stall = !room;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    // stream start wipes the queue and stop state before the byte goes in
    q0 = byte_word.stream_start ? '0 : bits;
    c0 = byte_word.stream_start ? '0 : count;
    s0 = byte_word.stream_start ? 1'b0 : stopped;

    qa = lfbp_pkg::append_byte(q0, c0, byte_word.data_byte);
    ca = c0 + lfbp_pkg::COUNT_BITS'(lfbp_pkg::BYTE_BITS);

    d1 = lfbp_pkg::decode_frame(qa, ca);
    if (d1.done) begin
      qb = lfbp_pkg::drop_frame(qa, d1.rec.frame_kind);
      cb = ca - d1.drop;
    end else begin
      qb = qa;
      cb = ca;
    end

    d2 = lfbp_pkg::decode_frame(qb, cb);
    if (!d1.done || d1.stop) begin
      d2.done = 1'b0;
      d2.stop = 1'b0;
    end

    bits_next    = bits;
    count_next   = count;
    stopped_next = stopped;
    push         = '0;
    push.word0   = d1.rec;
    push.word1   = d2.rec;
    push.word0.last_of_run = !d2.done;
    push.word1.last_of_run = 1'b1;

    if (accept) begin
      if (s0) begin
        // stopped stream: drop the byte
        bits_next    = q0;
        count_next   = c0;
        stopped_next = s0;
      end else if (d1.stop || d2.stop) begin
        bits_next    = '0;
        count_next   = '0;
        stopped_next = 1'b1;
        push.count   = d2.stop ? 2'd2 : 2'd1;
      end else if (d2.done) begin
        bits_next    = lfbp_pkg::drop_frame(qb, d2.rec.frame_kind);
        count_next   = cb - d2.drop;
        stopped_next = 1'b0;
        push.count   = 2'd2;
      end else begin
        bits_next    = qb;
        count_next   = cb;
        stopped_next = 1'b0;
        push.count   = d1.done ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits    <= '0;
      count   <= '0;
      stopped <= 1'b0;
    end else begin
      bits    <= bits_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

endmodule

FILE: design/lfbp_queue.sv
// Record queue between front end and output stage: two writes and one read per cycle.
`timescale 1ns / 1ps

module lfbp_queue #(
  parameter int DEPTH = lfbp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  lfbp_pkg::push_t     push,
  output logic                room,
  output logic                not_empty,
  input  logic                pop,
  output lfbp_pkg::out_word_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lfbp_pkg::out_word_t entries [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] fill;
  logic [PW-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + PW'(1);
  assign room         = fill <= CW'(DEPTH - 2);
  assign not_empty    = fill != '0;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.word0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill + CW'(push.count) - CW'(pop);
    end
  end

endmodule

FILE: design/lfbp_back.sv
// Output stage: moves records from the queue into the registered output word.
`timescale 1ns / 1ps

module lfbp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  lfbp_pkg::out_word_t head,
  output logic                pop,
  output logic                frame_valid,
  input  logic                frame_stall,
  output lfbp_pkg::out_word_t frame_word
);

  assign pop = not_empty && (!frame_valid || !frame_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || !frame_stall) begin
      frame_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_word <= head;
    end
  end

endmodule

FILE: design/lpc_frame_bitstream_parser_core.sv
// Top level of the LPC speech frame bitstream parser.
`timescale 1ns / 1ps

// Usage:
//   byte channel (byte_valid / byte_stall / byte_word): one stream byte per word,
//   bit 0 first; stream_start clears queued bits and the stop state first.
//   frame channel (frame_valid / frame_stall / frame_word): one record per
//   parsed frame (silent, repeat, unvoiced, voiced, stop), codes only;
//   last_of_run marks the last record that a byte produced.
// Throughput: one byte per cycle while the record queue has two free entries;
//   records leave one at a time, so a byte that finishes two frames takes two
//   output transfers. The front end parses both frames of a byte combinationally.
// Path: the accepting edge writes a record into the record queue; once popped,
//   it is loaded into the output register and shows on frame_word, with a
//   second record from the same byte behind it.
// Stalls: a record queue of QUEUE_DEPTH words parts the two sides; byte_stall
//   rises when fewer than two free entries remain, and records wait in the
//   queue and output register while frame_stall is high. Nothing is lost.
// Reset: clears the bit queue, the stop state and the record queue; no clearing
//   pass, bytes are taken in the first cycle after reset.
// After a stop record, bytes are taken and dropped until stream_start is set.
module lpc_frame_bitstream_parser_core #(
  // power of two, at least 2
  parameter int QUEUE_DEPTH = lfbp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  lfbp_pkg::in_word_t  byte_word,
  output logic                frame_valid,
  input  logic                frame_stall,
  output lfbp_pkg::out_word_t frame_word
);

  lfbp_pkg::push_t     push;
  lfbp_pkg::out_word_t head;
  logic                room;
  logic                not_empty;
  logic                pop;

  // parse bytes into records
  lfbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .room       (room),
    .push       (push)
  );

  // hold records until the output side takes them
  lfbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .not_empty (not_empty),
    .pop       (pop),
    .head      (head)
  );

  // drive the registered output word
  lfbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word)
  );

endmodule

FILE: test/lpc_frame_bitstream_parser_core_tb.sv
// Testbench for the LPC frame parser: random byte streams, predicted frame records, checks.
`timescale 1ns / 1ps

module lpc_frame_bitstream_parser_core_tb;
  import lfbp_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int IDLE_PCT       = 11;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_SPACING   = 700;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PRINT_CAP      = 40;

  // Frame tracker: mirrors the parser's bit queue and stop state, and holds
  // the records that the bytes taken so far should produce, oldest first.
  class lpc_frame_tracker;
    out_word_t   expected_frames[$];
    logic [63:0] bits;      // newest bit at bit 0
    int          nbits;
    bit          halted;
    int          taken;     // bytes that actually fed the bit queue
    int          errors;

    function new();
      bits   = '0;
      nbits  = 0;
      halted = 1'b0;
      taken  = 0;
      errors = 0;
    endfunction

    // Add a record at the tail of the expected list.
    function void expect_frame(out_word_t rec);
      expected_frames = {expected_frames, rec};
    endfunction

    // Field at a frame offset, first bit most significant.
    function logic [8:0] head_field(int off, int len);
      logic [63:0] v;
      v = bits >> (nbits - off - len);
      return 9'(v & ((64'd1 << len) - 64'd1));
    endfunction

    function void drop_head(int n);
      nbits -= n;
      if (nbits == 0) bits = '0;
      else bits &= (64'd1 << nbits) - 64'd1;
    endfunction

    // Note an accepted byte and queue the frame records it completes.
    function void note_byte(in_word_t w);
      out_word_t rec;
      int        made;
      int        need;
      if (w.stream_start) begin
        bits   = '0;
        nbits  = 0;
        halted = 1'b0;
      end
      if (halted) return;
      taken++;
      for (int i = 0; i < 8; i++) begin
        bits = {bits[62:0], w.data_byte[i]};
        nbits++;
      end
      made = 0;
      while (made < 2 && nbits >= LEN_ENERGY) begin
        rec = '0;
        rec.energy_index = 4'(head_field(0, 4));
        if (rec.energy_index == ENERGY_STOP) begin
          // stop: flush everything and drop bytes until the next stream start
          rec.frame_kind = KIND_STOP;
          halted = 1'b1;
          bits   = '0;
          nbits  = 0;
          expect_frame(rec);
          made++;
          break;
        end
        if (rec.energy_index == ENERGY_SILENT) begin
          rec.frame_kind = KIND_SILENT;
          drop_head(LEN_SILENT);
          expect_frame(rec);
          made++;
          continue;
        end
        if (nbits < LEN_REPEAT) break;
        rec.pitch_index = 6'(head_field(5, 6));
        // the repeat bit wins over a zero pitch
        if (head_field(4, 1) != 0) begin
          rec.frame_kind = KIND_REPEAT;
          drop_head(LEN_REPEAT);
          expect_frame(rec);
          made++;
          continue;
        end
        need = (rec.pitch_index == PITCH_NONE) ? LEN_UNVOICED : LEN_VOICED;
        if (nbits < need) break;
        rec.coef1_index = 5'(head_field(11, 5));
        rec.coef2_index = 5'(head_field(16, 5));
        rec.coef3_index = 4'(head_field(21, 4));
        rec.coef4_index = 4'(head_field(25, 4));
        if (need == LEN_UNVOICED) begin
          rec.frame_kind = KIND_UNVOICED;
        end else begin
          rec.frame_kind   = KIND_VOICED;
          rec.coef5_index  = 4'(head_field(29, 4));
          rec.coef6_index  = 4'(head_field(33, 4));
          rec.coef7_index  = 4'(head_field(37, 4));
          rec.coefs8_to_10 = head_field(41, 9);
        end
        drop_head(need);
        expect_frame(rec);
        made++;
      end
      if (made > 0) expected_frames[expected_frames.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Check one accepted record against the oldest expected one.
    task check_frame(out_word_t got);
      out_word_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("record %h with nothing expected", got));
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_kind",   got.frame_kind,   want.frame_kind);
      compare_field("energy_index", got.energy_index, want.energy_index);
      compare_field("pitch_index",  got.pitch_index,  want.pitch_index);
      compare_field("coef1_index",  got.coef1_index,  want.coef1_index);
      compare_field("coef2_index",  got.coef2_index,  want.coef2_index);
      compare_field("coef3_index",  got.coef3_index,  want.coef3_index);
      compare_field("coef4_index",  got.coef4_index,  want.coef4_index);
      compare_field("coef5_index",  got.coef5_index,  want.coef5_index);
      compare_field("coef6_index",  got.coef6_index,  want.coef6_index);
      compare_field("coef7_index",  got.coef7_index,  want.coef7_index);
      compare_field("coefs8_to_10", got.coefs8_to_10, want.coefs8_to_10);
      compare_field("last_of_run",  got.last_of_run,  want.last_of_run);
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_word_t  byte_word;
  logic      frame_valid;
  logic      frame_stall;
  out_word_t frame_word;

  lpc_frame_tracker tracker = new();

  bit stream_bits[$];       // bits waiting to be packed into bytes, oldest first
  int stall_run;            // cycles in a row with no word accepted
  int hold_left;            // remaining cycles of the long receiver hold-off
  int next_hold_at = 400;   // taken-byte count that triggers the next hold-off

  lpc_frame_bitstream_parser_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stretch in which neither side idles.
  function automatic bit quiet_stretch();
    return tracker.taken >= 700 && tracker.taken < 900;
  endfunction

  // Offer one word and hold it until the parser takes it. Random idle cycles
  // go in front so gaps land on every phase of the parser's work.
  task automatic send_byte(input in_word_t w);
    while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Add one bit at the tail of the pending stream.
  task automatic add_bit(input bit b);
    stream_bits = {stream_bits, b};
  endtask

  // Append a field, most significant bit first.
  task automatic put_field(input logic [38:0] v, input int len);
    for (int i = len - 1; i >= 0; i--) add_bit(v[i]);
  endtask

  // Append one frame. coefs holds k1..k10 back to back, k1 at the top.
  task automatic add_frame(input frame_kind_t kind, input logic [3:0] energy,
                           input logic [5:0] pitch, input logic [38:0] coefs);
    case (kind)
      KIND_SILENT: put_field(39'(ENERGY_SILENT), LEN_ENERGY);
      KIND_STOP:   put_field(39'(ENERGY_STOP), LEN_ENERGY);
      KIND_REPEAT: begin
        put_field(39'(energy), 4);
        put_field(39'd1, 1);
        put_field(39'(pitch), 6);
      end
      KIND_UNVOICED: begin
        put_field(39'(energy), 4);
        put_field(39'd0, 1);
        put_field(39'(PITCH_NONE), 6);
        put_field(39'(coefs[38:21]), 18);
      end
      default: begin
        put_field(39'(energy), 4);
        put_field(39'd0, 1);
        put_field(39'(pitch), 6);
        put_field(coefs, 39);
      end
    endcase
  endtask

  // Pad to a byte boundary with random bits and send the packed bytes, bit 0
  // first. With start_first the first byte opens a new stream; optionally corrupt one byte.
  task automatic send_bits(input bit start_first, input bit corrupt);
    in_word_t w;
    int       bad_at;
    int       idx;
    while (stream_bits.size() % 8 != 0) add_bit(1'($urandom_range(1)));
    bad_at = corrupt ? $urandom_range(stream_bits.size() / 8 - 1) : -1;
    idx = 0;
    while (stream_bits.size() > 0) begin
      for (int i = 0; i < 8; i++) w.data_byte[i] = stream_bits.pop_front();
      if (idx == bad_at) w.data_byte = 8'($urandom_range(255));
      w.stream_start = start_first && idx == 0;
      send_byte(w);
      idx++;
    end
  endtask

  // Well-formed stream with random content (one byte corrupted if corrupt is set), usually closed by a stop frame.
  task automatic random_stream(input bit corrupt);
    int          nframes;
    int          pick;
    frame_kind_t kind;
    logic [5:0]  pitch;
    nframes = $urandom_range(16, 2);
    for (int f = 0; f < nframes; f++) begin
      pick = $urandom_range(99);
      if (pick < 12)      kind = KIND_SILENT;
      else if (pick < 30) kind = KIND_REPEAT;
      else if (pick < 50) kind = KIND_UNVOICED;
      else                kind = KIND_VOICED;
      if (kind == KIND_VOICED)       pitch = 6'($urandom_range(63, 1));
      else if ($urandom_range(3) == 0) pitch = PITCH_NONE;
      else                           pitch = 6'($urandom_range(63));
      add_frame(kind, 4'($urandom_range(14, 1)), pitch,
                39'({$urandom(), $urandom()}));
    end
    if ($urandom_range(9) < 7) add_frame(KIND_STOP, ENERGY_STOP, PITCH_NONE, '0);
    send_bits(1'b1, corrupt);
  endtask

  task automatic noise_bytes(input int count);
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      w.data_byte    = 8'($urandom_range(255));
      w.stream_start = ($urandom_range(3) == 0);
      send_byte(w);
    end
  endtask

  // Monitor and watchdog: sample both handshakes at the edge, feed the
  // tracker, and end the run if nothing moves for too long.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        tracker.note_byte(byte_word);
        moved = 1'b1;
      end
      if (frame_valid && !frame_stall) begin
        tracker.check_frame(frame_word);
        moved = 1'b1;
      end
      stall_run = moved ? 0 : stall_run + 1;
      if (stall_run >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and now and then a long
  // hold-off so the record queue fills and the byte side backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      frame_stall <= 1'b1;
    end else if (tracker.taken >= next_hold_at) begin
      hold_left = HOLD_CYCLES - 1;
      next_hold_at += HOLD_SPACING;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= !quiet_stretch() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    int pick;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_word   = '0;
    frame_stall = 1'b0;
    stall_run   = 0;
    hold_left   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme field values, every frame kind, repeat with a zero
    // pitch, a stop followed by ignored bytes, a byte with two silent frames,
    // an immediate stop on a fresh stream, and a byte that completes nothing.
    add_frame(KIND_SILENT, ENERGY_SILENT, PITCH_NONE, '0);
    add_frame(KIND_VOICED, 4'd14, 6'd63, '1);
    add_frame(KIND_VOICED, 4'd1, 6'd1, '0);
    add_frame(KIND_UNVOICED, 4'd7, PITCH_NONE, '1);
    add_frame(KIND_REPEAT, 4'd9, PITCH_NONE, '0);
    add_frame(KIND_REPEAT, 4'd14, 6'd63, '0);
    add_frame(KIND_SILENT, ENERGY_SILENT, PITCH_NONE, '0);
    add_frame(KIND_STOP, ENERGY_STOP, PITCH_NONE, '0);
    send_bits(1'b1, 1'b0);
    send_byte('{data_byte: 8'hff, stream_start: 1'b0});
    send_byte('{data_byte: 8'h00, stream_start: 1'b1});
    send_byte('{data_byte: 8'hff, stream_start: 1'b1});
    send_byte('{data_byte: 8'h00, stream_start: 1'b0});
    send_byte('{data_byte: 8'h5a, stream_start: 1'b1});
    send_byte('{data_byte: 8'h00, stream_start: 1'b0});

    // Random: mostly well-formed streams, some with a corrupted byte, the
    // rest raw noise with random stream starts.
    while (tracker.taken < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 82) random_stream(pick >= 72);
      else noise_bytes($urandom_range(8, 1));
    end

    // Drain: release the byte side, wait for every record, then a short tail.
    byte_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: lpc_frame_bitstream_parser_core.f
design/lfbp_pkg.sv
design/lfbp_front.sv
design/lfbp_queue.sv
design/lfbp_back.sv
design/lpc_frame_bitstream_parser_core.sv
test/lpc_frame_bitstream_parser_core_tb.sv
